[hw/rtl/command_frame_checker_assert.svh]
// assertion macros for the command frame checker
`ifndef COMMAND_FRAME_CHECKER_ASSERT_SVH
`define COMMAND_FRAME_CHECKER_ASSERT_SVH

`ifndef SYNTH
`define CFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define CFC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define CFC_ASSERT(lbl, prop, msg)
`define CFC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[hw/rtl/cfc_pkg.sv]
package cfc_pkg;

    localparam int NUM_IDS    = 6;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_ID_BOOT          = 3'd0;
    localparam logic [2:0] REG_ID_GOTO_BOOT     = 3'd1;
    localparam logic [2:0] REG_ID_GET_INFO      = 3'd2;
    localparam logic [2:0] REG_ID_ERASE_FLASH   = 3'd3;
    localparam logic [2:0] REG_ID_DATA_TRANSFER = 3'd4;
    localparam logic [2:0] REG_ID_CHECK_FLASH   = 3'd5;
    localparam logic [2:0] REG_MAX_FRAME_LEN    = 3'd6;

    localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd256;

    // frame status codes
    localparam logic [2:0] ST_WAIT    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_BADLEN  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_BADSUM  = 3'd4;
    localparam logic [2:0] ST_OVERRUN = 3'd5;

    localparam logic [7:0] SUM_GOOD      = 8'hFF;
    localparam logic [7:0] ERR_ID_OFFSET = 8'h90;

    // byte positions within the header
    localparam logic [16:0] POS_ID     = 17'd1;
    localparam logic [16:0] POS_LEN_HI = 17'd2;
    localparam logic [16:0] POS_LEN_LO = 17'd3;

    // allowed length per frame type; the data transfer upper bound is max_frame_len
    localparam logic [15:0] LEN_LO [NUM_IDS] = '{16'd2, 16'd1, 16'd2, 16'd1, 16'd7, 16'd5};
    localparam logic [15:0] LEN_HI [NUM_IDS] = '{16'd2, 16'd1, 16'd2, 16'd1, 16'd0, 16'd5};

    typedef struct packed {
        logic [NUM_IDS-1:0][7:0] ids;
        logic [15:0]             max_frame_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [2:0]  frame_status;
        logic [7:0]  reply_id;
        logic [15:0] message_length;
    } t_out_item;

endpackage

[hw/rtl/cfc_regs.sv]
module cfc_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cfc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cfc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cfc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output cfc_pkg::t_cfg                    o_cfg
);
    import cfc_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_IDS; i++) begin
                r_cfg.ids[i] <= 8'(i);
            end
            r_cfg.max_frame_len <= MAX_FRAME_LEN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ID_BOOT:          r_cfg.ids[REG_ID_BOOT]          <= pwdata[7:0];
                REG_ID_GOTO_BOOT:     r_cfg.ids[REG_ID_GOTO_BOOT]     <= pwdata[7:0];
                REG_ID_GET_INFO:      r_cfg.ids[REG_ID_GET_INFO]      <= pwdata[7:0];
                REG_ID_ERASE_FLASH:   r_cfg.ids[REG_ID_ERASE_FLASH]   <= pwdata[7:0];
                REG_ID_DATA_TRANSFER: r_cfg.ids[REG_ID_DATA_TRANSFER] <= pwdata[7:0];
                REG_ID_CHECK_FLASH:   r_cfg.ids[REG_ID_CHECK_FLASH]   <= pwdata[7:0];
                REG_MAX_FRAME_LEN:    r_cfg.max_frame_len             <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ID_BOOT:          prdata = {24'd0, r_cfg.ids[REG_ID_BOOT]};
            REG_ID_GOTO_BOOT:     prdata = {24'd0, r_cfg.ids[REG_ID_GOTO_BOOT]};
            REG_ID_GET_INFO:      prdata = {24'd0, r_cfg.ids[REG_ID_GET_INFO]};
            REG_ID_ERASE_FLASH:   prdata = {24'd0, r_cfg.ids[REG_ID_ERASE_FLASH]};
            REG_ID_DATA_TRANSFER: prdata = {24'd0, r_cfg.ids[REG_ID_DATA_TRANSFER]};
            REG_ID_CHECK_FLASH:   prdata = {24'd0, r_cfg.ids[REG_ID_CHECK_FLASH]};
            REG_MAX_FRAME_LEN:    prdata = {16'd0, r_cfg.max_frame_len};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/command_frame_checker.sv]
// command frame checker
// input channel: one frame byte per request (data_byte, frame_start), valid/stall.
// frame_start marks the id byte; then a big-endian 16-bit length L and L bytes,
// the last of them the checksum. every accepted byte gives exactly one result
// request on the output channel: payload pass-through plus status, reply id and
// message length.
// the result of an accepted byte is registered in the output register, or in the
// skid register when the output register is held. throughput: one byte per cycle
// while o_in_stall is low; the per-byte work (header compare, six-entry id match,
// 8-bit checksum add) is one combinational step before the output registers.
// when the receiver stalls, a skid register holds one more result; o_in_stall
// rises only once that skid register is occupied, so no result is lost.
// reset (synchronous, active low) empties the output side, clears the frame
// state and loads the register defaults; there is no clearing pass, the block
// takes bytes in the first cycle after reset.
// registers sit on the apb port: ids 0..5 at 0x00..0x14, max_frame_len at 0x18.
module command_frame_checker #(
    parameter int NUM_FRAME_TYPES = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cfc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cfc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cfc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  cfc_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output cfc_pkg::t_out_item               o_out_item
);
    import cfc_pkg::*;

    `include "command_frame_checker_assert.svh"

    t_cfg cfg;

    cfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // frame state
    logic [16:0] r_byte_count, n_byte_count;
    logic [7:0]  r_held_id,    n_held_id;
    logic [15:0] r_held_length, n_held_length;
    logic [7:0]  r_sum,        n_sum;
    logic        r_closed,     n_closed;

    // output side
    logic        r_out_valid,  n_out_valid;
    logic        r_skid_valid, n_skid_valid;
    t_out_item   r_out_item,   n_out_item;
    t_out_item   r_skid_item,  n_skid_item;

    logic        in_accept;
    logic        out_fire;
    logic [7:0]  in_byte;
    logic [16:0] cnt_base;
    logic [7:0]  sum_base;
    logic        closed_base;
    logic [16:0] pos;
    logic [16:0] last_pos;
    logic [7:0]  sum_new;
    logic [2:0]  hdr_status;
    logic [15:0] hi_bound;
    t_out_item   result;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid & ~r_skid_valid;
    assign out_fire   = r_out_valid & ~i_out_stall;

    assign in_byte     = i_in_item.data_byte;
    assign cnt_base    = i_in_item.frame_start ? '0   : r_byte_count;
    assign sum_base    = i_in_item.frame_start ? '0   : r_sum;
    assign closed_base = i_in_item.frame_start ? 1'b0 : r_closed;
    assign pos         = cnt_base + 17'd1;
    assign last_pos    = {1'b0, r_held_length} + 17'd3;
    assign sum_new     = sum_base + in_byte;

    // id and length as they stand once this byte is taken
    always_comb begin
        n_held_id     = r_held_id;
        n_held_length = r_held_length;
        if (!closed_base) begin
            if (pos == POS_ID) begin
                n_held_id = in_byte;
            end else if (pos == POS_LEN_HI) begin
                n_held_length = {in_byte, 8'd0};
            end else if (pos == POS_LEN_LO) begin
                n_held_length = {r_held_length[15:8], in_byte};
            end
        end
    end

    // header check, lowest matching table entry wins
    always_comb begin
        hdr_status = ST_UNKNOWN;
        hi_bound   = '0;
        for (int k = NUM_FRAME_TYPES - 1; k >= 0; k--) begin
            if (cfg.ids[k] == n_held_id) begin
                hi_bound = (k == int'(REG_ID_DATA_TRANSFER)) ? cfg.max_frame_len : LEN_HI[k];
                if (n_held_length < LEN_LO[k] || n_held_length > hi_bound) begin
                    hdr_status = ST_BADLEN;
                end else begin
                    hdr_status = ST_WAIT;
                end
            end
        end
        if (n_held_length > cfg.max_frame_len) begin
            hdr_status = ST_BADLEN;
        end
    end

    always_comb begin
        n_byte_count         = cnt_base;
        n_sum                = sum_base;
        n_closed             = closed_base;
        result.payload_valid = 1'b0;
        result.payload_byte  = '0;
        result.frame_status  = ST_WAIT;
        if (!closed_base) begin
            if (pos <= POS_LEN_LO) begin
                n_byte_count = pos;
                n_sum        = sum_new;
                if (pos == POS_LEN_LO) begin
                    result.frame_status = hdr_status;
                    n_closed            = (hdr_status != ST_WAIT);
                end
            end else if (pos <= last_pos) begin
                n_byte_count         = pos;
                n_sum                = sum_new;
                result.payload_valid = 1'b1;
                result.payload_byte  = in_byte;
                if (pos == last_pos) begin
                    result.frame_status = (sum_new == SUM_GOOD) ? ST_OK : ST_BADSUM;
                    n_closed            = (sum_new != SUM_GOOD);
                end
            end else begin
                // byte past the checksum of a good frame
                result.frame_status = ST_OVERRUN;
                n_closed            = 1'b1;
            end
        end
        if (result.frame_status inside {[ST_BADLEN:ST_OVERRUN]}) begin
            result.reply_id       = n_held_id + ERR_ID_OFFSET;
            result.message_length = 16'd1;
        end else if (result.frame_status == ST_OK) begin
            result.reply_id       = n_held_id;
            result.message_length = n_held_length - 16'd1;
        end else begin
            result.reply_id       = n_held_id;
            result.message_length = '0;
        end
    end

    // output register with one skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        n_skid_valid = r_skid_valid;
        n_skid_item  = r_skid_item;
        if (in_accept) begin
            if (!r_out_valid || out_fire) begin
                n_out_valid = 1'b1;
                n_out_item  = result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_item  = result;
            end
        end else if (out_fire) begin
            if (r_skid_valid) begin
                n_out_item   = r_skid_item;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_held_id     <= '0;
            r_held_length <= '0;
            r_sum         <= '0;
            r_closed      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_byte_count  <= n_byte_count;
                r_held_id     <= n_held_id;
                r_held_length <= n_held_length;
                r_sum         <= n_sum;
                r_closed      <= n_closed;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_skid_item <= n_skid_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `CFC_ASSERT(a_skid_needs_out, r_skid_valid |-> r_out_valid, "skid full while output empty")
    `CFC_ASSERT(a_payload_zero,
        (r_out_valid && !r_out_item.payload_valid) |-> (r_out_item.payload_byte == 8'd0),
        "payload byte set without payload_valid")
    `CFC_ASSERT(a_error_length,
        (r_out_valid && (r_out_item.frame_status == ST_BADLEN ||
         r_out_item.frame_status == ST_UNKNOWN || r_out_item.frame_status == ST_BADSUM ||
         r_out_item.frame_status == ST_OVERRUN)) |-> (r_out_item.message_length == 16'd1),
        "error result without message length one")
    `CFC_ASSERT(a_stall_fill,
        (r_out_valid && i_out_stall && in_accept) |=> r_skid_valid,
        "accepted byte under stall did not land in skid")
    `CFC_ASSERT_RST(a_reset_empty, !i_rst_n |=> (!o_out_valid && !o_in_stall),
        "output side not empty after reset")

endmodule
